@@ rtl/spc_pkg.sv @@
// spc_pkg: shared types and constants for the sector pair correlation block
// used by rtl/sector_pair_correlation.sv; no dependencies
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int MAX_RADII  = 32;
    localparam int BIN_AW     = $clog2(MAX_RADII);
    localparam int NB_W       = 6;
    localparam int DIV_NUM_W  = 80;
    localparam int DIV_DEN_W  = 31;
    localparam int DIV_CNT_W  = 7;
    localparam int SQ_STEPS   = 32;
    localparam int SQ_CNT_W   = 6;

    localparam logic [62:0] EST_MAX = {63{1'b1}};

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_RADIUS  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_DIR_X         = 3'd0,
        REG_DIR_Y         = 3'd1,
        REG_COS_THETA     = 3'd2,
        REG_BANDWIDTH     = 3'd3,
        REG_CORRECTION_ON = 3'd4,
        REG_BOX_LEN_X     = 3'd5,
        REG_BOX_LEN_Y     = 3'd6,
        REG_RADIUS_COUNT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PAIR_RD,
        S_PAIR_DIFF,
        S_PAIR_MUL,
        S_PAIR_SUM,
        S_SQRT,
        S_SECTOR_MUL,
        S_SECTOR_TEST,
        S_BIN_RD,
        S_BIN_ERR,
        S_DIV_S,
        S_SQ,
        S_KERNEL,
        S_DIV_V,
        S_DIV_T,
        S_DIV_C,
        S_ACC,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

endpackage

@@ rtl/sector_pair_correlation.sv @@
// sector_pair_correlation: point and radius stores, pair sweep, kernel sums
// depends on spc_pkg
`timescale 1ns / 1ps

// Command block. clear (func 0), append point (func 1) and write radius (func 2)
// complete while busy stays low. compute (func 3) with a nonzero radius count
// raises busy, sweeps every unordered point pair and then emits one estimate
// per bin in use on strobe, with last on the final bin; results cannot be held
// off. A pair with nonzero distance runs one bit-serial square root of 32 steps;
// each bin that a pair reaches takes up to two divisions on the shared bit-serial
// divider, or up to four with edge correction.
// Pairs and bins are worked one after another through the point, radius and
// bin-sum memories.
module sector_pair_correlation
    import spc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [30:0] coord_x,
    input  logic signed [30:0] coord_y,
    input  logic [30:0]        radius,
    input  logic [4:0]         slot,
    output logic               strobe,
    output logic [4:0]         bin_index,
    output logic [62:0]        estimate,
    output logic               last
);

    // configuration
    logic signed [17:0] dir_x_reg, dir_y_reg;
    logic [16:0]        cos_theta_reg;
    logic [30:0]        bandwidth_reg, box_len_x_reg, box_len_y_reg;
    logic               correction_on_reg;
    logic [5:0]         radius_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg         <= 18'sd65536;
            dir_y_reg         <= 18'sd0;
            cos_theta_reg     <= '0;
            bandwidth_reg     <= 31'd65536;
            correction_on_reg <= 1'b0;
            box_len_x_reg     <= 31'd65536;
            box_len_y_reg     <= 31'd65536;
            radius_count_reg  <= 6'd32;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIR_X:         dir_x_reg         <= cfg_data[17:0];
                REG_DIR_Y:         dir_y_reg         <= cfg_data[17:0];
                REG_COS_THETA:     cos_theta_reg     <= cfg_data[16:0];
                REG_BANDWIDTH:     bandwidth_reg     <= cfg_data;
                REG_CORRECTION_ON: correction_on_reg <= cfg_data[0];
                REG_BOX_LEN_X:     box_len_x_reg     <= cfg_data;
                REG_BOX_LEN_Y:     box_len_y_reg     <= cfg_data;
                REG_RADIUS_COUNT:  radius_count_reg  <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic   accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    logic [CNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]  i_reg, j_reg;
    logic [BIN_AW-1:0] k_reg;
    logic [NB_W-1:0]   nb_reg;
    logic [30:0]       h_reg;
    logic [MAX_RADII-1:0] bin_vld_reg;

    // memories
    logic [30:0] pt_x_mem [MAX_POINTS];
    logic [30:0] pt_y_mem [MAX_POINTS];
    logic [30:0] rad_mem  [MAX_RADII];
    logic [62:0] bin_mem  [MAX_RADII];
    logic [30:0] xi_rd, xj_rd, yi_rd, yj_rd, rad_rd;
    logic [62:0] bin_rd;
    logic [62:0] acc_sum;

    logic do_append;
    assign do_append = accept && (func_t'(func) == FUNC_APPEND)
                       && (point_count_reg < CNT_W'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            pt_x_mem[point_count_reg[PT_AW-1:0]] <= coord_x;
            pt_y_mem[point_count_reg[PT_AW-1:0]] <= coord_y;
        end
        if (state_reg == S_PAIR_RD)
        begin
            xi_rd <= pt_x_mem[i_reg[PT_AW-1:0]];
            xj_rd <= pt_x_mem[j_reg[PT_AW-1:0]];
            yi_rd <= pt_y_mem[i_reg[PT_AW-1:0]];
            yj_rd <= pt_y_mem[j_reg[PT_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (func_t'(func) == FUNC_RADIUS))
            rad_mem[slot] <= radius;
        if (state_reg == S_BIN_RD)
            rad_rd <= rad_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC)
            bin_mem[k_reg] <= acc_sum;
        if (state_reg == S_BIN_RD || state_reg == S_EMIT_RD)
            bin_rd <= bin_mem[k_reg];
    end

    // shared bit-serial divider, one quotient bit a cycle
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num_in;
    logic [DIV_DEN_W-1:0] div_den_in;
    logic [DIV_NUM_W-1:0] div_num_reg, div_quo_reg;
    logic [DIV_DEN_W-1:0] div_den_reg, div_rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_DEN_W:0]   div_rem_sh, div_diff;
    logic                 div_fits, div_done;

    assign div_rem_sh = {div_rem_reg, div_num_reg[DIV_NUM_W-1]};
    assign div_diff   = div_rem_sh - {1'b0, div_den_reg};
    assign div_fits   = (div_rem_sh >= {1'b0, div_den_reg});
    assign div_done   = (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (div_start)
            div_cnt_reg <= DIV_CNT_W'(DIV_NUM_W);
        else if (!div_done)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_num_reg <= div_num_in;
            div_den_reg <= div_den_in;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else if (!div_done)
        begin
            div_num_reg <= {div_num_reg[DIV_NUM_W-2:0], 1'b0};
            div_rem_reg <= div_fits ? div_diff[DIV_DEN_W-1:0] : div_rem_sh[DIV_DEN_W-1:0];
            div_quo_reg <= {div_quo_reg[DIV_NUM_W-2:0], div_fits};
        end
    end

    // digit-by-digit square root, one root bit a cycle
    logic          sq_start;
    logic [63:0]   sq_rad_reg;
    logic [33:0]   sq_rem_reg;
    logic [31:0]   sq_root_reg;
    logic [SQ_CNT_W:0] sq_cnt_reg;
    logic [35:0]   sq_rem_sh, sq_trial;
    logic          sq_fits, sq_done;
    logic [63:0]   d2;

    assign sq_rem_sh = {sq_rem_reg, sq_rad_reg[63:62]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    assign sq_fits   = (sq_rem_sh >= sq_trial);
    assign sq_done   = (sq_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_cnt_reg <= '0;
        else if (sq_start)
            sq_cnt_reg <= (SQ_CNT_W+1)'(SQ_STEPS);
        else if (!sq_done)
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sq_start)
        begin
            sq_rad_reg  <= d2;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (!sq_done)
        begin
            sq_rad_reg  <= {sq_rad_reg[61:0], 2'b00};
            sq_rem_reg  <= sq_fits ? 34'(sq_rem_sh - sq_trial) : sq_rem_sh[33:0];
            sq_root_reg <= {sq_root_reg[30:0], sq_fits};
        end
    end

    // pair datapath
    logic signed [31:0] dx_reg, dy_reg;
    logic [31:0]        adx, ady;
    logic [63:0]        adx_sq_reg, ady_sq_reg;
    logic signed [49:0] dot_x_reg, dot_y_reg;
    logic signed [50:0] dot_reg;
    logic [50:0]        dot_mag_reg;
    logic [48:0]        ctd_reg;
    logic [31:0]        d_reg;
    logic [30:0]        wx_reg, wy_reg;
    logic [31:0]        s_reg;
    logic [63:0]        ss_reg;
    logic [62:0]        contrib_reg;

    assign adx = dx_reg[31] ? 32'(-dx_reg) : 32'(dx_reg);
    assign ady = dy_reg[31] ? 32'(-dy_reg) : 32'(dy_reg);
    assign d2  = adx_sq_reg + ady_sq_reg;

    logic [31:0] e_val;
    logic [31:0] f_val;
    logic [33:0] f3_val;
    logic        sector_ok, box_ok;
    logic [63:0] sum64;

    assign e_val  = (d_reg > {1'b0, rad_rd}) ? d_reg - {1'b0, rad_rd}
                                             : {1'b0, rad_rd} - d_reg;
    assign f_val  = 32'h8000_0000 - ss_reg[62:31];
    assign f3_val = {1'b0, f_val, 1'b0} + {2'b00, f_val};
    assign sector_ok = ({2'b00, ctd_reg} < dot_mag_reg);
    assign box_ok    = !correction_on_reg
                       || (({1'b0, box_len_x_reg} > adx) && ({1'b0, box_len_y_reg} > ady));
    assign sum64   = {1'b0, (bin_vld_reg[k_reg] ? bin_rd : 63'd0)} + {1'b0, contrib_reg};
    assign acc_sum = sum64[63] ? EST_MAX : sum64[62:0];

    // pair and bin stepping
    logic             more_j, more_i, last_bin;
    logic [NB_W-1:0]  nb_cfg;
    logic             next_pair, next_bin;
    logic             ld_contrib;
    logic [62:0]      contrib_in;

    assign more_j   = ({1'b0, j_reg} + 1'b1) < {1'b0, point_count_reg};
    assign more_i   = ({1'b0, i_reg} + 2'd2) < {1'b0, point_count_reg};
    assign last_bin = ({1'b0, k_reg} == (nb_reg - 1'b1));
    assign nb_cfg   = (radius_count_reg > NB_W'(MAX_RADII)) ? NB_W'(MAX_RADII)
                                                            : radius_count_reg;

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num_in = '0;
        div_den_in = h_reg;
        sq_start   = 1'b0;
        next_pair  = 1'b0;
        next_bin   = 1'b0;
        ld_contrib = 1'b0;
        contrib_in = div_quo_reg[62:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (func_t'(func) == FUNC_COMPUTE) && (nb_cfg != '0))
                begin
                    if (point_count_reg < CNT_W'(2))
                        state_next = S_EMIT_RD;
                    else
                        state_next = S_PAIR_RD;
                end
            end
            S_PAIR_RD:    state_next = S_PAIR_DIFF;
            S_PAIR_DIFF:  state_next = S_PAIR_MUL;
            S_PAIR_MUL:   state_next = S_PAIR_SUM;
            S_PAIR_SUM:
            begin
                if (d2 == '0)
                    next_pair = 1'b1;
                else
                begin
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_done)
                    state_next = S_SECTOR_MUL;
            end
            S_SECTOR_MUL: state_next = S_SECTOR_TEST;
            S_SECTOR_TEST:
            begin
                if (sector_ok && box_ok)
                    state_next = S_BIN_RD;
                else
                    next_pair = 1'b1;
            end
            S_BIN_RD:     state_next = S_BIN_ERR;
            S_BIN_ERR:
            begin
                if (e_val > {1'b0, h_reg})
                    next_bin = 1'b1;
                else
                begin
                    div_start  = 1'b1;
                    div_num_in = {17'd0, e_val, 31'd0};
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                if (div_done)
                    state_next = S_SQ;
            end
            S_SQ:         state_next = S_KERNEL;
            S_KERNEL:
            begin
                div_start  = 1'b1;
                div_num_in = {31'd0, f3_val, 15'd0};
                state_next = S_DIV_V;
            end
            S_DIV_V:
            begin
                if (div_done)
                begin
                    if (div_quo_reg == '0)
                        next_bin = 1'b1;
                    else if (correction_on_reg)
                    begin
                        div_start  = 1'b1;
                        div_num_in = {div_quo_reg[63:0], 16'd0};
                        div_den_in = wx_reg;
                        state_next = S_DIV_T;
                    end
                    else
                    begin
                        ld_contrib = 1'b1;
                        state_next = S_ACC;
                    end
                end
            end
            S_DIV_T:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_num_in = {div_quo_reg[63:0], 16'd0};
                    div_den_in = wy_reg;
                    state_next = S_DIV_C;
                end
            end
            S_DIV_C:
            begin
                if (div_done)
                begin
                    ld_contrib = 1'b1;
                    // quotient beyond 63 bits saturates
                    contrib_in = (div_quo_reg[79:63] != '0) ? EST_MAX : div_quo_reg[62:0];
                    state_next = S_ACC;
                end
            end
            S_ACC:        next_bin = 1'b1;
            S_EMIT_RD:    state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (last_bin)
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT_RD;
            end
            default:      state_next = S_IDLE;
        endcase

        if (next_bin)
        begin
            if (last_bin)
                next_pair = 1'b1;
            else
                state_next = S_BIN_RD;
        end
        if (next_pair)
        begin
            if (more_j || more_i)
                state_next = S_PAIR_RD;
            else
                state_next = S_EMIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            nb_reg          <= '0;
            h_reg           <= 31'd1;
            bin_vld_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (func_t'(func) == FUNC_CLEAR))
                point_count_reg <= '0;
            else if (do_append)
                point_count_reg <= point_count_reg + 1'b1;

            if (state_reg == S_IDLE && accept && (func_t'(func) == FUNC_COMPUTE))
            begin
                nb_reg      <= nb_cfg;
                h_reg       <= (bandwidth_reg == '0) ? 31'd1 : bandwidth_reg;
                bin_vld_reg <= '0;
                i_reg       <= '0;
                j_reg       <= CNT_W'(1);
                k_reg       <= '0;
            end
            if (state_reg == S_SECTOR_TEST)
                k_reg <= '0;
            if (state_reg == S_ACC)
                bin_vld_reg[k_reg] <= 1'b1;
            if (next_bin && !last_bin)
                k_reg <= k_reg + 1'b1;
            if (next_pair)
            begin
                k_reg <= '0;
                if (more_j)
                    j_reg <= j_reg + 1'b1;
                else if (more_i)
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + CNT_W'(2);
                end
            end
            if (state_reg == S_EMIT_OUT && !last_bin)
                k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_PAIR_DIFF:
            begin
                dx_reg <= {xi_rd[30], xi_rd} - {xj_rd[30], xj_rd};
                dy_reg <= {yi_rd[30], yi_rd} - {yj_rd[30], yj_rd};
            end
            S_PAIR_MUL:
            begin
                adx_sq_reg <= adx * adx;
                ady_sq_reg <= ady * ady;
                dot_x_reg  <= dx_reg * dir_x_reg;
                dot_y_reg  <= dy_reg * dir_y_reg;
            end
            S_PAIR_SUM:
                dot_reg <= {dot_x_reg[49], dot_x_reg} + {dot_y_reg[49], dot_y_reg};
            S_SQRT:
                d_reg <= sq_root_reg;
            S_SECTOR_MUL:
            begin
                ctd_reg     <= cos_theta_reg * d_reg;
                dot_mag_reg <= dot_reg[50] ? 51'(-dot_reg) : 51'(dot_reg);
            end
            S_SECTOR_TEST:
            begin
                wx_reg <= 31'({1'b0, box_len_x_reg} - adx);
                wy_reg <= 31'({1'b0, box_len_y_reg} - ady);
            end
            S_DIV_S:
                s_reg <= div_quo_reg[31:0];
            S_SQ:
                ss_reg <= s_reg * s_reg;
            default: ;
        endcase
        if (ld_contrib)
            contrib_reg <= contrib_in;
    end

    // result word
    logic        strobe_reg, last_reg;
    logic [4:0]  bin_index_reg;
    logic [62:0] estimate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= (state_reg == S_EMIT_OUT);
            last_reg   <= (state_reg == S_EMIT_OUT) && last_bin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT_OUT)
        begin
            bin_index_reg <= k_reg;
            estimate_reg  <= bin_vld_reg[k_reg] ? bin_rd : 63'd0;
        end
    end

    assign strobe    = strobe_reg;
    assign last      = last_reg;
    assign bin_index = bin_index_reg;
    assign estimate  = estimate_reg;

    // checks
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe) else $error("last without strobe");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("result word outside compute");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR_RD) |-> (i_reg < j_reg && j_reg < point_count_reg))
        else $error("pair indices out of order");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_done) else $error("divider restarted while running");

endmodule
